[sv/mjt_pkg.sv]
// Shared types, constants and beat layouts for the mining job tracker.
package mjt_pkg;

	localparam int JOB_SLOTS_DEF = 128;
	localparam int ID_W          = 7;
	localparam int VER_W         = 32;
	localparam int NONCE_W       = 32;
	localparam int VFIELD_W      = 16;
	localparam int ROLL_SHIFT    = 13;
	localparam logic [ID_W-1:0] ID_STEP = 7'd24;

	localparam logic CMD_ISSUE  = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	typedef struct packed {
		logic                command;
		logic [VER_W-1:0]    job_version;
		logic [7:0]          report_id_byte;
		logic [NONCE_W-1:0]  report_nonce;
		logic [VFIELD_W-1:0] report_version_field;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]    assigned_id;
		logic               report_valid;
		logic [ID_W-1:0]    decoded_job_id;
		logic [6:0]         core_number;
		logic [3:0]         small_core_number;
		logic [NONCE_W-1:0] nonce_out;
		logic [VER_W-1:0]   version_out;
	} res_t;

	// What the lookup stage hands to the result stage.
	typedef struct packed {
		logic                is_report;
		logic                hit;
		logic [ID_W-1:0]     assigned_id;
		logic [ID_W-1:0]     decoded_job_id;
		logic [6:0]          core_number;
		logic [3:0]          small_core_number;
		logic [NONCE_W-1:0]  nonce;
		logic [VFIELD_W-1:0] vfield;
	} s1_t;

endpackage

[sv/mjt_cmd_if.sv]
// Command channel interface: valid/ready handshake with a command beat.
interface mjt_cmd_if;
	logic          valid;
	logic          ready;
	mjt_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/mjt_res_if.sv]
// Result channel interface: valid/ready handshake with a result beat.
interface mjt_res_if;
	logic          valid;
	logic          ready;
	mjt_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/mjt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mjt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[sv/mjt_lookup.sv]
// Lookup stage: job counter, slot valid bits, version RAM and the stage 1 register.
module mjt_lookup #(
	parameter int JOB_SLOTS = mjt_pkg::JOB_SLOTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	mjt_cmd_if.sink                 cmd,
	input  logic                    advance,
	output logic                    valid_s1,
	output mjt_pkg::s1_t            data_s1,
	output logic [mjt_pkg::VER_W-1:0] ver_s1
);
	localparam int SlotW = $clog2(JOB_SLOTS);

	logic [mjt_pkg::ID_W-1:0] counter_q;
	logic [mjt_pkg::ID_W-1:0] next_id;
	logic [mjt_pkg::ID_W-1:0] rpt_id;
	logic [JOB_SLOTS-1:0]     slot_valid_q;
	logic                     accept, issue, report;
	logic                     issue_in_range, rpt_in_range;
	logic [SlotW-1:0]         widx, ridx;
	mjt_pkg::s1_t             nxt;

	assign cmd.ready = !valid_s1 || advance;
	assign accept    = cmd.valid && cmd.ready;
	assign issue     = accept && (cmd.data.command == mjt_pkg::CMD_ISSUE);
	assign report    = accept && (cmd.data.command == mjt_pkg::CMD_REPORT);

	assign next_id        = counter_q + mjt_pkg::ID_STEP;
	assign rpt_id         = {cmd.data.report_id_byte[7:4], 3'b000};
	assign issue_in_range = 32'(next_id) < JOB_SLOTS;
	assign rpt_in_range   = 32'(rpt_id) < JOB_SLOTS;
	assign widx           = SlotW'(next_id);
	assign ridx           = SlotW'(rpt_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q    <= '0;
			slot_valid_q <= '0;
		end else if (issue) begin
			counter_q <= next_id;
			if (issue_in_range) begin
				slot_valid_q[widx] <= 1'b1;
			end
		end
	end

	always_comb begin
		nxt                   = '0;
		nxt.is_report         = cmd.data.command == mjt_pkg::CMD_REPORT;
		nxt.assigned_id       = next_id;
		nxt.decoded_job_id    = rpt_id;
		nxt.core_number       = cmd.data.report_nonce[31:25];
		nxt.small_core_number = cmd.data.report_id_byte[3:0];
		nxt.nonce             = cmd.data.report_nonce;
		nxt.vfield            = cmd.data.report_version_field;
		nxt.hit               = rpt_in_range && slot_valid_q[ridx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= nxt;
		end
	end

	// Read data holds while the stage stalls: a read only fires on a report beat.
	mjt_ram #(
		.WIDTH (mjt_pkg::VER_W),
		.DEPTH (JOB_SLOTS)
	) u_ver_ram (
		.clk   (clk),
		.we    (issue && issue_in_range),
		.waddr (widx),
		.wdata (cmd.data.job_version),
		.re    (report),
		.raddr (ridx),
		.rdata (ver_s1)
	);
endmodule

[sv/mjt_result.sv]
// Result stage: forms the result beat and holds it in the output register.
module mjt_result (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  mjt_pkg::s1_t              data_s1,
	input  logic [mjt_pkg::VER_W-1:0] ver_s1,
	output logic                      advance,
	mjt_res_if.source                 res
);
	logic          out_valid_q;
	mjt_pkg::res_t res_q;
	mjt_pkg::res_t nxt;
	logic [mjt_pkg::VER_W-1:0] roll_bits;

	assign roll_bits = {3'b000, data_s1.vfield, 13'b0};
	assign advance   = !out_valid_q || res.ready;

	always_comb begin
		nxt = '0;
		if (data_s1.is_report) begin
			nxt.report_valid      = data_s1.hit;
			nxt.decoded_job_id    = data_s1.decoded_job_id;
			nxt.core_number       = data_s1.core_number;
			nxt.small_core_number = data_s1.small_core_number;
			nxt.nonce_out         = data_s1.nonce;
			nxt.version_out       = data_s1.hit ? (ver_s1 | roll_bits) : '0;
		end else begin
			nxt.assigned_id = data_s1.assigned_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= nxt;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = res_q;
endmodule

[sv/mining_job_tracker_core.sv]
// Top level of the mining job tracker: issues job ids and checks nonce reports.
//
//  channel | dir | beat  | contents
//  --------+-----+-------+---------------------------------------------------
//  cmd     | in  | cmd_t | issue (version) or report (id byte, nonce, vfield)
//  res     | out | res_t | assigned id, or decoded report and rolled version
//
// One beat per cycle sustained while res is ready. Stage 1 registers the
// command, its slot valid bit and the version RAM read; the result stage forms
// the beat in the output register that follows stage 1.
// Reset clears the job counter and all slot valid bits; the version RAM is not
// cleared, an unwritten slot is never read as valid.
// A stall on res holds both stages; cmd.ready drops only when both are full.
module mining_job_tracker_core #(
	parameter int JOB_SLOTS = mjt_pkg::JOB_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mjt_cmd_if.sink    cmd,
	mjt_res_if.source  res
);
	logic                      valid_s1;
	mjt_pkg::s1_t              data_s1;
	logic [mjt_pkg::VER_W-1:0] ver_s1;
	logic                      advance;

	// Counter, valid bits and version RAM; registers the looked-up beat.
	mjt_lookup #(
		.JOB_SLOTS (JOB_SLOTS)
	) u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.ver_s1   (ver_s1)
	);

	// Field muxing and output register.
	mjt_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.ver_s1   (ver_s1),
		.advance  (advance),
		.res      (res)
	);

`ifndef NO_ASSERTIONS
	// Both stages full and output stalled: no new command may be taken.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res.valid && !res.ready) |-> !cmd.ready)
		else $error("command taken while both stages are full");

	// A valid report beat never carries an assigned id.
	a_report_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.report_valid) |-> (res.data.assigned_id == '0))
		else $error("report beat with nonzero assigned id");

	// A miss never returns a version.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.data.report_valid) |-> (res.data.version_out == '0))
		else $error("invalid report returned a version");

	// Ids step by 24 mod 128, so they stay multiples of eight.
	a_id_step: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.data.assigned_id[2:0] == 3'b000))
		else $error("assigned id off the step grid");
`endif
endmodule

[test/mjt_job_checker.sv]
// Job tracker checker: watches both channels, predicts each result beat and compares it.
`timescale 1ns / 1ps

module mjt_job_checker #(
	parameter int JOB_SLOTS = mjt_pkg::JOB_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mjt_cmd_if   cmd_mon,
	mjt_res_if   res_mon,
	output int   fail_count,
	output int   pending
);

	logic [mjt_pkg::ID_W-1:0]  job_counter;
	logic                      slot_live [JOB_SLOTS];
	logic [mjt_pkg::VER_W-1:0] slot_ver  [JOB_SLOTS];
	mjt_pkg::res_t             expected_results [$];

	initial fail_count = 0;

	task automatic report_error(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_error($sformatf("%s got %0h expected %0h", name, got, want));
		end
	endtask

	// Updates the job table for an issue; a report only reads it.
	function automatic mjt_pkg::res_t predict_job_result(input mjt_pkg::cmd_t c);
		mjt_pkg::res_t            r;
		logic [mjt_pkg::ID_W-1:0] jid;
		logic                     hit;
		r = '0;
		if (c.command == mjt_pkg::CMD_ISSUE) begin
			job_counter = job_counter + mjt_pkg::ID_STEP;
			if (int'(job_counter) < JOB_SLOTS) begin
				slot_ver[job_counter]  = c.job_version;
				slot_live[job_counter] = 1'b1;
			end
			r.assigned_id = job_counter;
		end else begin
			jid = {c.report_id_byte[7:4], 3'b000};
			hit = (int'(jid) < JOB_SLOTS) && slot_live[jid];
			r.report_valid      = hit;
			r.decoded_job_id    = jid;
			r.core_number       = c.report_nonce[31:25];
			r.small_core_number = c.report_id_byte[3:0];
			r.nonce_out         = c.report_nonce;
			if (hit) begin
				r.version_out = slot_ver[jid]
					| ({16'h0, c.report_version_field} << mjt_pkg::ROLL_SHIFT);
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		mjt_pkg::res_t want;
		if (!arst_n) begin
			job_counter = '0;
			for (int i = 0; i < JOB_SLOTS; i++) slot_live[i] = 1'b0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				if (expected_results.size() == 0) begin
					report_error("result beat with nothing expected");
				end else begin
					want = expected_results.pop_front();
					compare_field("assigned_id", 32'(res_mon.data.assigned_id),
						32'(want.assigned_id));
					compare_field("report_valid", 32'(res_mon.data.report_valid),
						32'(want.report_valid));
					compare_field("decoded_job_id", 32'(res_mon.data.decoded_job_id),
						32'(want.decoded_job_id));
					compare_field("core_number", 32'(res_mon.data.core_number),
						32'(want.core_number));
					compare_field("small_core_number",
						32'(res_mon.data.small_core_number),
						32'(want.small_core_number));
					compare_field("nonce_out", res_mon.data.nonce_out, want.nonce_out);
					compare_field("version_out", res_mon.data.version_out,
						want.version_out);
				end
			end
			if (cmd_mon.valid && cmd_mon.ready) begin
				expected_results.push_back(predict_job_result(cmd_mon.data));
			end
			pending <= expected_results.size();
		end
	end

endmodule

[test/testbench.sv]
// Testbench top: drives job issues and nonce reports into the tracker and gives the verdict.
`timescale 1ns / 1ps

module testbench;

	localparam int RANDOM_BEATS = 750;
	localparam int PAUSE_AT     = 375;   // sender drains the pipe here once
	localparam int STEADY_LO    = 200;   // beats in [LO,HI) run with no idling
	localparam int STEADY_HI    = 300;
	localparam int IDLE_LIMIT   = 4000;  // cycles with no beat on either channel

	logic clk;
	logic arst_n;
	logic steady;
	int   stall_left;
	int   idle_cycles;
	int   fail_count;
	int   pending;

	mjt_cmd_if cmd_ch ();
	mjt_res_if res_ch ();

	mining_job_tracker_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	mjt_job_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_mon    (cmd_ch),
		.res_mon    (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mostly no gap, some short ones, a few long enough to drain the pipe.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Result side backpressure. Stalls land on any stage state since the
	// sender gaps are drawn independently.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_ch.ready <= 1'b0;
		end else if (!steady && arst_n && $urandom_range(0, 99) < 25) begin
			stall_left <= pick_gap();
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Watchdog: a hang shows up as a long run of cycles with no beat at all.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic mjt_pkg::cmd_t issue_beat(input logic [31:0] version);
		mjt_pkg::cmd_t c;
		c = '0;
		c.command     = mjt_pkg::CMD_ISSUE;
		c.job_version = version;
		return c;
	endfunction

	function automatic mjt_pkg::cmd_t report_beat(input logic [7:0] id_byte,
			input logic [31:0] nonce, input logic [15:0] vfield);
		mjt_pkg::cmd_t c;
		c = '0;
		c.command              = mjt_pkg::CMD_REPORT;
		c.report_id_byte       = id_byte;
		c.report_nonce         = nonce;
		c.report_version_field = vfield;
		return c;
	endfunction

	// Random beat; unused fields carry noise too, the block must ignore them.
	// Version and nonce now and then sit at their extremes.
	function automatic mjt_pkg::cmd_t random_beat();
		mjt_pkg::cmd_t c;
		c.command              = ($urandom_range(0, 99) < 45) ? mjt_pkg::CMD_ISSUE
		                                                      : mjt_pkg::CMD_REPORT;
		c.job_version          = $urandom;
		c.report_id_byte       = 8'($urandom_range(0, 255));
		c.report_nonce         = $urandom;
		c.report_version_field = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 15))
			0: begin
				c.job_version  = '1;
				c.report_nonce = '1;
			end
			1: begin
				c.job_version  = '0;
				c.report_nonce = '0;
			end
			default: ;
		endcase
		return c;
	endfunction

	// Called at a clock edge. Holds the beat until accepted, then maybe idles.
	// valid is only lowered when a gap follows, so a back-to-back beat never
	// sees valid dropped and raised in one step.
	task automatic push_beat(input mjt_pkg::cmd_t b);
		int gap;
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= b;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		steady       = 1'b0;
		stall_left   = 0;
		idle_cycles  = 0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		res_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reports before any issue: every slot is still invalid, decoded
		// fields must come through anyway. All-zero and all-ones fields.
		push_beat(report_beat(8'h00, 32'h0000_0000, 16'h0000));
		push_beat(report_beat(8'hff, 32'hffff_ffff, 16'hffff));
		// First issues land on 24 and 48.
		push_beat(issue_beat(32'h0000_0000));
		push_beat(issue_beat(32'hffff_ffff));
		// Rolled bits over a zero version, then over an all-ones version.
		push_beat(report_beat(8'h3a, 32'h8000_0001, 16'hffff));
		push_beat(report_beat(8'h6f, 32'h7fff_fffe, 16'h0000));
		// Report right behind the issue of its own slot (72).
		push_beat(issue_beat(32'h2000_0004));
		push_beat(report_beat(8'h95, 32'h0200_0000, 16'h8001));
		// Walk the counter through the rest of the reachable slots, ending on 0.
		for (int i = 0; i < 13; i++) begin
			push_beat(issue_beat($urandom));
		end
		// Counter wraps: slot 24 is reissued and its old version overwritten.
		push_beat(issue_beat(32'h5555_aaaa));
		push_beat(report_beat(8'h35, $urandom, 16'h1234));
		push_beat(report_beat(8'h0c, $urandom, 16'h4321));

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			steady <= (i >= STEADY_LO && i < STEADY_HI);
			push_beat(random_beat());
			if (i == PAUSE_AT) begin
				// Hold off the sender until every result is out.
				cmd_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		cmd_ch.valid <= 1'b0;
		steady       <= 1'b0;

		// Drain, then keep watching to catch stray result beats.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

[sim.f]
sv/mjt_pkg.sv
sv/mjt_cmd_if.sv
sv/mjt_res_if.sv
sv/mjt_ram.sv
sv/mjt_lookup.sv
sv/mjt_result.sv
sv/mining_job_tracker_core.sv
test/mjt_job_checker.sv
test/testbench.sv
